[src/assert_macros.svh]
// Assertion helpers used by the top-level decoder file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clock, muted while reset is high.
`define SESD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge of clock, reset included.
`define SESD_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/sesd_pkg.sv]
`default_nettype none

package sesd_pkg;

   typedef enum logic [1:0] {
      KIND_NOTE  = 2'd0,
      KIND_DELAY = 2'd1,
      KIND_END   = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_LEAD  = 3'b001,
      PH_DATA1 = 3'b010,
      PH_DATA2 = 3'b100
   } phase_type;

   localparam int ACC_W    = 20;
   localparam int CFG_W    = 24;
   localparam int FRAMES_W = 28;
   localparam int DUR_W    = 15;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = ACC_W + CFG_W;

   localparam logic [ACC_W-1:0]    ACC_MAX    = '1;
   localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;
   localparam logic [CFG_W-1:0]    CFG_RESET  = 24'd2890138;
   localparam logic [PROD_W:0]     ROUND_HALF = 45'h8000;

   localparam logic [3:0] LEAD_SHORT = 4'h8;
   localparam logic [3:0] LEAD_MID   = 4'h9;
   localparam logic [3:0] LEAD_LONG  = 4'hA;

   // One queued command: an optional delay or note result, then an optional end or error.
   typedef struct packed {
      logic             a_valid;
      logic             a_note;
      logic [ACC_W-1:0] delay_ms;
      logic [3:0]       channel;
      logic [6:0]       note;
      logic [6:0]       velocity;
      logic [DUR_W-1:0] duration_ms;
      logic             b_valid;
      kind_type         b_kind;
   } cmd_type;

   typedef struct packed {
      kind_type            kind;
      logic [3:0]          channel;
      logic [6:0]          note;
      logic [6:0]          velocity;
      logic [DUR_W-1:0]    duration_ms;
      logic [FRAMES_W-1:0] delay_frames;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

[src/sesd_front.sv]
`default_nettype none

module sesd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        song_byte,
   input  wire logic              first,
   input  wire logic              final_req,
   output logic                   push,
   output sesd_pkg::cmd_type      cmd
);
   import sesd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       lead_ff, lead_in;
   logic [7:0]       first_data_ff, first_data_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             stopped_ff, stopped_in;

   phase_type        eff_phase;
   logic [ACC_W-1:0] eff_acc;
   logic             eff_stopped;

   logic [12:0]      delay_ms;
   logic [ACC_W:0]   acc_sum;
   logic [ACC_W-1:0] acc_sat;
   logic [6:0]       vel_raw;
   logic [6:0]       vel_dec;
   logic [5:0]       span;
   logic [DUR_W-1:0] dur_dec;

   // Delay byte value: short form in ms, long form in 64 ms units
   assign delay_ms = song_byte[6] ? {7'(song_byte[5:0]) + 7'd1, 6'b0}
                                  : {7'b0, song_byte[5:0]};
   assign acc_sum  = {1'b0, eff_acc} + (ACC_W + 1)'(delay_ms);
   assign acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

   assign vel_raw = {first_data_ff[0], song_byte[7:2]};
   assign span    = 6'(song_byte[4:0]) + 6'd1;

   always_comb begin
      if (lead_ff[7:4] == LEAD_SHORT) begin
         vel_dec = vel_raw;
         dur_dec = {9'b0, song_byte[1:0], 4'b0};
      end else begin
         vel_dec = {vel_raw[6:3], vel_raw[6:4]};
         dur_dec = (lead_ff[7:4] == LEAD_MID) ? {3'b0, span, 6'b0} : {span, 9'b0};
      end
   end

   always_comb begin
      eff_phase   = phase_ff;
      eff_acc     = acc_ff;
      eff_stopped = stopped_ff;
      if (first) begin
         eff_phase   = PH_LEAD;
         eff_acc     = '0;
         eff_stopped = 1'b0;
      end

      phase_in      = phase_ff;
      acc_in        = acc_ff;
      stopped_in    = stopped_ff;
      lead_in       = lead_ff;
      first_data_in = first_data_ff;
      cmd           = '0;

      if (accept) begin
         phase_in   = eff_phase;
         acc_in     = eff_acc;
         stopped_in = eff_stopped;
         if (!eff_stopped) begin
            case (eff_phase)
               PH_DATA1: begin
                  first_data_in = song_byte;
                  phase_in      = PH_DATA2;
                  if (final_req) begin
                     cmd.b_valid = 1'b1;
                     cmd.b_kind  = KIND_ERROR;
                     stopped_in  = 1'b1;
                     phase_in    = PH_LEAD;
                  end
               end
               PH_DATA2: begin
                  cmd.a_valid     = 1'b1;
                  cmd.a_note      = 1'b1;
                  cmd.channel     = lead_ff[3:0];
                  cmd.note        = first_data_ff[7:1];
                  cmd.velocity    = vel_dec;
                  cmd.duration_ms = dur_dec;
                  phase_in        = PH_LEAD;
                  if (final_req) begin
                     cmd.b_valid = 1'b1;
                     cmd.b_kind  = KIND_END;
                     stopped_in  = 1'b1;
                  end
               end
               default: begin
                  if (song_byte[7]) begin
                     // flush any pending delay ahead of the lead byte
                     cmd.a_valid  = (eff_acc != '0);
                     cmd.delay_ms = eff_acc;
                     acc_in       = '0;
                     if (song_byte[7:4] inside {LEAD_SHORT, LEAD_MID, LEAD_LONG}) begin
                        lead_in  = song_byte;
                        phase_in = PH_DATA1;
                        if (final_req) begin
                           cmd.b_valid = 1'b1;
                           cmd.b_kind  = KIND_ERROR;
                           stopped_in  = 1'b1;
                           phase_in    = PH_LEAD;
                        end
                     end else begin
                        cmd.b_valid = 1'b1;
                        cmd.b_kind  = KIND_ERROR;
                        stopped_in  = 1'b1;
                     end
                  end else if (song_byte == 8'h00) begin
                     cmd.a_valid  = (eff_acc != '0);
                     cmd.delay_ms = eff_acc;
                     acc_in       = '0;
                     cmd.b_valid  = 1'b1;
                     cmd.b_kind   = KIND_END;
                     stopped_in   = 1'b1;
                  end else begin
                     acc_in = acc_sat;
                     if (final_req) begin
                        cmd.a_valid  = 1'b1;
                        cmd.delay_ms = acc_sat;
                        acc_in       = '0;
                        cmd.b_valid  = 1'b1;
                        cmd.b_kind   = KIND_END;
                        stopped_in   = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   assign push = cmd.a_valid | cmd.b_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         acc_ff     <= '0;
         stopped_ff <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff       <= lead_in;
      first_data_ff <= first_data_in;
   end

endmodule

`default_nettype wire

[src/sesd_queue.sv]
`default_nettype none

module sesd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sesd_pkg::cmd_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output sesd_pkg::cmd_type      head
);
   import sesd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/sesd_back.sv]
`default_nettype none

module sesd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [sesd_pkg::CFG_W-1:0] frames_per_ms_q16,
   input  wire logic                       q_empty,
   input  wire sesd_pkg::cmd_type          head,
   output logic                            pop,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output sesd_pkg::rsp_type               rsp
);
   import sesd_pkg::*;

   logic              stg_valid_ff, stg_valid_in;
   logic              a_done_ff, a_done_in;
   cmd_type           stg_cmd_ff, stg_cmd_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic                  out_free;
   logic                  emit_a;
   logic                  step;
   logic                  stg_done;
   logic [PROD_W:0]       rounded;
   logic [PROD_W-FRAC_W:0] whole;
   logic [FRAMES_W-1:0]   frames;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit_a   = stg_valid_ff && stg_cmd_ff.a_valid && !a_done_ff;
   assign step     = stg_valid_ff && out_free;
   assign stg_done = step && (!emit_a || !stg_cmd_ff.b_valid);
   assign pop      = (!stg_valid_ff || stg_done) && !q_empty;

   // Round half up, then saturate to the frame count width
   assign rounded = {1'b0, prod_ff} + ROUND_HALF;
   assign whole   = rounded[PROD_W:FRAC_W];
   assign frames  = whole[FRAMES_W] ? FRAMES_MAX : whole[FRAMES_W-1:0];

   always_comb begin
      stg_valid_in = stg_valid_ff;
      a_done_in    = a_done_ff;
      stg_cmd_in   = stg_cmd_ff;
      prod_in      = prod_ff;
      if (pop) begin
         stg_valid_in = 1'b1;
         a_done_in    = 1'b0;
         stg_cmd_in   = head;
         prod_in      = PROD_W'(head.delay_ms) * PROD_W'(frames_per_ms_q16);
      end else begin
         if (stg_done) begin
            stg_valid_in = 1'b0;
         end
         if (step && emit_a) begin
            a_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = stg_valid_ff;
         rsp_in       = '0;
         if (emit_a) begin
            rsp_in.last = !stg_cmd_ff.b_valid;
            if (stg_cmd_ff.a_note) begin
               rsp_in.kind        = KIND_NOTE;
               rsp_in.channel     = stg_cmd_ff.channel;
               rsp_in.note        = stg_cmd_ff.note;
               rsp_in.velocity    = stg_cmd_ff.velocity;
               rsp_in.duration_ms = stg_cmd_ff.duration_ms;
            end else begin
               rsp_in.kind         = KIND_DELAY;
               rsp_in.delay_frames = frames;
            end
         end else begin
            rsp_in.kind = stg_cmd_ff.b_kind;
            rsp_in.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         a_done_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         a_done_ff    <= a_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_cmd_ff <= stg_cmd_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

[src/song_event_stream_decoder.sv]
`default_nettype none
`include "assert_macros.svh"

// Song event stream decoder. Takes one song byte per transaction on the req_ side and
// produces note, delay, end and error results on the rsp_ side. The front parser accepts
// one byte every cycle whenever the command queue (QUEUE_DEPTH entries) has room, so
// req_tready drops only when the back end falls behind. Each byte yields zero, one or two
// results; the back end delivers one result per cycle while rsp_tready is high, and that
// output rate sets the sustained throughput. A byte that reaches an empty back end shows
// its first result on rsp_ once it has passed, in order, the command queue, the delay
// multiply stage (20 x 24 bit ms times frames-per-ms) and the output register. Write
// csr_wr_data only while the block is idle.
module song_event_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: frames_per_ms_q16
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] song_byte
   input  wire logic        req_tuser,   // [0] first
   input  wire logic        req_tlast,   // final_req
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [3:0] channel, [10:4] note, [17:11] velocity,
                                         // [32:18] duration_ms, [60:33] delay_frames,
                                         // [63:61] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last_of_run
);
   import sesd_pkg::*;

   logic [CFG_W-1:0] frames_per_ms_ff, frames_per_ms_in;

   logic    req_accept;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type front_cmd;
   cmd_type q_head;
   rsp_type rsp_res;
   logic    start_with_end;
   logic    rsp_stop;

   // Hold the rate register until a write arrives
   assign frames_per_ms_in = csr_wr_en ? csr_wr_data : frames_per_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_per_ms_ff <= CFG_RESET;
      end else begin
         frames_per_ms_ff <= frames_per_ms_in;
      end
   end

   // Accept a byte whenever the queue can take its command
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   sesd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .song_byte (req_tdata),
      .first     (req_tuser),
      .final_req (req_tlast),
      .push      (q_push),
      .cmd       (front_cmd)
   );

   sesd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   sesd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .frames_per_ms_q16 (frames_per_ms_ff),
      .q_empty           (q_empty),
      .head              (q_head),
      .pop               (q_pop),
      .rsp_ready         (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp               (rsp_res)
   );

   // Pack the result fields, lowest field in the lowest bits
   assign rsp_tdata = {3'b000, rsp_res.delay_frames, rsp_res.duration_ms, rsp_res.velocity,
                       rsp_res.note, rsp_res.channel};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

   // Terms for the checks below: a song opened by an end byte, and a stopping result
   assign start_with_end = req_accept && req_tuser && (req_tdata == 8'h00);
   assign rsp_stop       = rsp_tvalid && (rsp_res.kind inside {KIND_END, KIND_ERROR});

   `SESD_ASSERT(a_queue_no_overflow, !(q_push && q_full), "command queued while queue full")
   `SESD_ASSERT_NORST(a_reset_clears_rsp, reset |=> !rsp_tvalid, "result valid after reset")
   `SESD_ASSERT(a_first_zero_queues_end, start_with_end |-> q_push, "song end not queued")
   `SESD_ASSERT(a_end_error_is_last, rsp_stop |-> rsp_tlast, "end or error not last")

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import sesd_pkg::*;

   // Cycles to let pass once nothing is expected, to cover the three-stage output path
   // and any byte still in flight that produces no result.
   localparam int DRAIN_CYCLES = 8;
   // Cycles without any transaction or register write before the run is abandoned.
   localparam int STALL_LIMIT  = 1000;

   // Every input of the block starts at a known value.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] song_byte
   logic        req_tuser   = 1'b0; // [0] first
   logic        req_tlast   = 1'b0; // final_req
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [3:0] channel, [10:4] note, [17:11] velocity,
                                    // [32:18] duration_ms, [60:33] delay_frames
   logic [1:0]  rsp_tuser;          // [1:0] kind
   logic        rsp_tlast;          // last_of_run

   song_event_stream_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Decoder prediction: a private copy of the parser state and the frame-rate register.
   // ---------------------------------------------------------------------------------
   rsp_type             pending_results[$];
   phase_type           parse_phase;
   logic [7:0]          held_lead;
   logic [7:0]          held_data;
   logic [ACC_W-1:0]    rest_ms;
   logic                song_stopped;
   logic [CFG_W-1:0]    frames_per_ms;
   int                  results_this_byte;

   // Run statistics.
   int parsed_bytes    = 0;
   int ignored_bytes   = 0;
   int results_checked = 0;
   int settings_used   = 0;
   int mismatches      = 0;

   function automatic void queue_result(kind_type kind, logic [3:0] channel,
                                        logic [6:0] note, logic [6:0] velocity,
                                        logic [DUR_W-1:0] duration,
                                        logic [FRAMES_W-1:0] frames);
      rsp_type r;
      r.kind         = kind;
      r.channel      = channel;
      r.note         = note;
      r.velocity     = velocity;
      r.duration_ms  = duration;
      r.delay_frames = frames;
      r.last         = 1'b0;
      pending_results.push_back(r);
      results_this_byte++;
   endfunction

   // Convert the accumulated rest into frames, rounding half up, and clear it.
   function automatic void flush_rest();
      logic [44:0] product;
      logic [28:0] scaled;
      if (rest_ms != '0) begin
         product = {25'd0, rest_ms} * {21'd0, frames_per_ms} + 45'h8000;
         scaled  = product[44:16];
         queue_result(KIND_DELAY, '0, '0, '0, '0,
                      (scaled > {1'b0, FRAMES_MAX}) ? FRAMES_MAX : scaled[FRAMES_W-1:0]);
         rest_ms = '0;
      end
   endfunction

   function automatic void stop_song(kind_type kind);
      queue_result(kind, '0, '0, '0, '0, '0);
      song_stopped = 1'b1;
      parse_phase  = PH_LEAD;
   endfunction

   function automatic void end_song();
      flush_rest();
      stop_song(KIND_END);
   endfunction

   function automatic void decode_song_byte(logic [7:0] value, logic first, logic fin);
      logic [6:0]       velocity;
      logic [DUR_W-1:0] duration;
      logic [12:0]      step_ms;
      logic [ACC_W:0]   sum_ms;
      rsp_type          tail;
      results_this_byte = 0;
      if (first) begin
         parse_phase  = PH_LEAD;
         held_lead    = '0;
         held_data    = '0;
         rest_ms      = '0;
         song_stopped = 1'b0;
      end
      if (song_stopped) begin
         ignored_bytes++;
         return;
      end
      parsed_bytes++;
      case (parse_phase)
         PH_DATA1: begin
            held_data   = value;
            parse_phase = PH_DATA2;
            if (fin) stop_song(KIND_ERROR);
         end
         PH_DATA2: begin
            velocity = {held_data[0], value[7:2]};
            if (held_lead[7:4] == LEAD_SHORT) begin
               duration = {9'd0, value[1:0], 4'd0};
            end else begin
               // coarse velocity: keep the top nibble and mirror it into the bottom
               velocity = velocity & 7'h78;
               velocity = velocity | (velocity >> 4);
               duration = ({10'd0, value[4:0]} + 15'd1)
                          << ((held_lead[7:4] == LEAD_MID) ? 6 : 9);
            end
            queue_result(KIND_NOTE, held_lead[3:0], held_data[7:1], velocity, duration, '0);
            parse_phase = PH_LEAD;
            if (fin) end_song();
         end
         default: begin
            if (value[7]) begin
               flush_rest();
               if (value[7:4] == LEAD_SHORT || value[7:4] == LEAD_MID ||
                   value[7:4] == LEAD_LONG) begin
                  held_lead   = value;
                  parse_phase = PH_DATA1;
                  if (fin) stop_song(KIND_ERROR);
               end else begin
                  stop_song(KIND_ERROR);
               end
            end else if (value == 8'd0) begin
               end_song();
            end else begin
               step_ms = value[6] ? (({7'd0, value[5:0]} + 13'd1) << 6) : {5'd0, value};
               sum_ms  = {1'b0, rest_ms} + {8'd0, step_ms};
               rest_ms = (sum_ms > {1'b0, ACC_MAX}) ? ACC_MAX : sum_ms[ACC_W-1:0];
               if (fin) end_song();
            end
         end
      endcase
      // mark the final result raised by this byte
      if (results_this_byte > 0) begin
         tail      = pending_results.pop_back();
         tail.last = 1'b1;
         pending_results.push_back(tail);
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         $error("result with nothing expected: kind %0d, data %h", rsp_tuser, rsp_tdata);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      results_checked++;
      check_field("kind",         32'(want.kind),         32'(rsp_tuser));
      check_field("channel",      32'(want.channel),      32'(rsp_tdata[3:0]));
      check_field("note",         32'(want.note),         32'(rsp_tdata[10:4]));
      check_field("velocity",     32'(want.velocity),     32'(rsp_tdata[17:11]));
      check_field("duration_ms",  32'(want.duration_ms),  32'(rsp_tdata[32:18]));
      check_field("delay_frames", 32'(want.delay_frames), 32'(rsp_tdata[60:33]));
      check_field("last_of_run",  32'(want.last),         32'(rsp_tlast));
   endfunction

   // Sample at each rising edge, the same instant the block does: register writes first,
   // then the accepted byte is decoded, then any accepted result is checked.
   always @(posedge clock) begin
      if (reset) begin
         parse_phase   = PH_LEAD;
         held_lead     = '0;
         held_data     = '0;
         rest_ms       = '0;
         song_stopped  = 1'b1;
         frames_per_ms = CFG_RESET;
      end else begin
         if (csr_wr_en) frames_per_ms = csr_wr_data;
         if (req_tvalid && req_tready) decode_song_byte(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // Watchdog: abandon the run after a long stretch without any transaction.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver back-pressure: each stretch picks always ready, random stalls, or a
   // repeating eight-slot mask with at least one ready slot.
   int       stall_stretch = 0;
   int       stall_mode    = 0;
   logic [7:0] stall_mask  = 8'hFF;
   logic [2:0] stall_slot  = '0;
   always @(posedge clock) begin
      if (stall_stretch == 0) begin
         stall_mode    = $urandom_range(0, 2);
         stall_mask    = 8'($urandom_range(1, 255));
         stall_stretch = $urandom_range(40, 300);
      end else begin
         stall_stretch--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: begin
            rsp_tready <= stall_mask[stall_slot];
            stall_slot++;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   int burst_left    = 0;
   bit start_pending = 1'b0;

   // Offer one byte and hold it until the transaction completes. Between bursts drop
   // tvalid for a random gap; a zero gap chains bursts back to back.
   task automatic send_byte(input logic [7:0] value, input logic first, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a byte of the current song; the first byte after a song opens carries first.
   task automatic send_in_song(input logic [7:0] value, input logic fin);
      send_byte(value, start_pending, fin);
      start_pending = 1'b0;
   endtask

   task automatic send_note(input logic fin);
      send_in_song({4'h8 + 4'($urandom_range(0, 2)), 4'($urandom_range(0, 15))}, 1'b0);
      send_in_song(8'($urandom_range(0, 255)), 1'b0);
      send_in_song(8'($urandom_range(0, 255)), fin);
   endtask

   // Write the frame-rate register once the block has drained.
   task automatic write_register(input logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   // Hand-picked bytes at the reset setting: every lead kind, extreme data bytes, both
   // delay encodings, and each way a song can end, stop or restart.
   task automatic test_directed_cases();
      send_byte(8'h05, 1'b1, 1'b0);   // open with a short rest
      send_byte(8'h40, 1'b0, 1'b0);   // smallest long rest
      send_byte(8'h7F, 1'b0, 1'b0);   // largest long rest
      send_byte(8'h80, 1'b0, 1'b0);   // lead flushes the pending rest first
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h9F, 1'b0, 1'b0);   // zero data bytes are data, not an end
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);   // longest duration
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);   // zero byte with final_req as well
      send_byte(8'h90, 1'b0, 1'b0);   // no song running: dropped
      send_byte(8'hB3, 1'b1, 1'b0);   // bad lead nibble
      send_byte(8'h10, 1'b1, 1'b0);
      send_byte(8'hF0, 1'b0, 1'b0);   // rest then bad lead
      send_byte(8'h85, 1'b1, 1'b1);   // cut short on the lead
      send_byte(8'h85, 1'b1, 1'b0);
      send_byte(8'h10, 1'b0, 1'b1);   // cut short on the first data byte
      send_byte(8'h20, 1'b1, 1'b0);
      send_byte(8'h3F, 1'b0, 1'b1);   // final_req on a rest
      send_byte(8'h95, 1'b1, 1'b0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h81, 1'b1, 1'b0);   // new song mid-event drops the partial note
      send_byte(8'h22, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b1);   // final_req on the closing data byte
      send_byte(8'h01, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);   // explicit end with a rest pending
   endtask

   // A short song under each extreme of the frame rate, above 13107200 too, then at 65536 and the reset setting.
   task automatic test_register_extremes();
      logic [CFG_W-1:0] settings[6];
      settings = '{24'd0, 24'd1, 24'd13107200, 24'hFFFFFF, 24'd65536, CFG_RESET};
      foreach (settings[i]) begin
         write_register(settings[i]);
         start_pending = 1'b1;
         send_in_song(8'h7F, 1'b0);
         send_in_song(8'h01, 1'b0);
         send_note(1'b0);
         send_in_song(8'($urandom_range(1, 127)), 1'b0);
         send_in_song(8'h00, 1'b0);
      end
   endtask

   // Enough long rests to pin the accumulator at its ceiling, at the highest rate.
   task automatic test_rest_saturation();
      write_register(24'hFFFFFF);
      start_pending = 1'b1;
      repeat (260) send_in_song(8'h7F, 1'b0);
      send_in_song(8'($urandom_range(1, 127)), 1'b0);
      send_note(1'b1);
   endtask

   // One random song: mostly well-formed notes and rests, with bad leads, restarts
   // mid-event, cut-short events and stray bytes after the end mixed in.
   task automatic random_song();
      int events;
      int pick;
      start_pending = 1'b1;
      events = $urandom_range(1, 12);
      repeat (events) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_note(1'b0);
         end else if (pick < 80) begin
            send_in_song(8'($urandom_range(1, 127)), 1'b0);
         end else if (pick < 85) begin
            send_in_song(8'($urandom_range(8'hB0, 8'hFF)), 1'b0);
         end else if (pick < 90) begin
            // abandon an event halfway; the next byte reopens the song
            send_in_song({4'h8 + 4'($urandom_range(0, 2)), 4'($urandom_range(0, 15))}, 1'b0);
            if ($urandom_range(0, 1)) send_in_song(8'($urandom_range(0, 255)), 1'b0);
            start_pending = 1'b1;
         end else begin
            repeat ($urandom_range(2, 6)) send_in_song(8'($urandom_range(1, 127)), 1'b0);
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_in_song(8'h00, 1'($urandom_range(0, 1)));
      end else if (pick < 55) begin
         send_note(1'b1);
      end else if (pick < 70) begin
         send_in_song(8'($urandom_range(1, 127)), 1'b1);
      end else if (pick < 80) begin
         send_in_song({4'h8 + 4'($urandom_range(0, 2)), 4'($urandom_range(0, 15))},
                      pick < 75);
         if (pick >= 75) send_in_song(8'($urandom_range(0, 255)), 1'b1);
      end
      // stray bytes after the song, dropped unless the song never ended
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   task automatic test_random_songs();
      int target;
      int songs;
      target = parsed_bytes + 60;
      songs  = 0;
      while (parsed_bytes < target) begin
         if (songs % 10 == 0) begin
            case ($urandom_range(0, 9))
               0:       write_register('0);
               1:       write_register(24'd13107200);
               2:       write_register(24'($urandom_range(13107201, 24'hFFFFFF)));
               default: write_register(24'($urandom_range(0, 13107200)));
            endcase
         end
         random_song();
         songs++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_rest_saturation();
      test_random_songs();
      // Drain: wait for every expected result, then for anything stray.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Decoded %0d song bytes (%0d dropped while stopped), %0d results checked,",
               parsed_bytes, ignored_bytes, results_checked);
      $display("across %0d frame-rate settings with stalls on both streams.", settings_used);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
